// ===== rtl/core/llcc_pkg.sv =====
// Shared widths, reset values, register indexes and state encoding for the
// laser line column centroid block. No dependencies.
package llcc_pkg;

   localparam int PIXEL_W    = 8;
   localparam int COLUMN_W   = 11;
   localparam int CENTROID_W = 11;
   localparam int DIM_W      = 12;
   localparam int SUM_W      = 22;
   localparam int CNT_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 2048;

   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd128;
   localparam logic [DIM_W-1:0]   DIM_RESET       = 12'd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

endpackage

// ===== rtl/core/llcc_channels_if.sv =====
// Handshake channels of the laser line column centroid block: pixel input,
// result output and register write port. Depends on llcc_pkg.
interface llcc_req_if import llcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface llcc_rsp_if import llcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  bin_pixel;
   logic [COLUMN_W-1:0]   column;
   logic                  centroid_valid;
   logic [CENTROID_W-1:0] centroid_row;
   logic                  last_of_frame;

   modport source (output valid, output bin_pixel, output column, output centroid_valid,
                   output centroid_row, output last_of_frame, input ready);
   modport sink   (input valid, input bin_pixel, input column, input centroid_valid,
                   input centroid_row, input last_of_frame, output ready);
endinterface

interface llcc_csr_if import llcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/laser_line_column_centroid.sv =====
// Laser line column centroid: binarizes a raster-order frame and reports the
// per-column centroid row on the last row. Depends on llcc_pkg, llcc_channels_if.
//
// Usage:
//   req_ch  - one grayscale pixel per item, frames in raster order.
//   rsp_ch  - one result item per pixel: binarized pixel, column index, and on
//             the last row the truncated mean row of that column's bright pixels.
//   csr_ch  - register writes (threshold, frame_width, frame_height), always
//             ready; write only while no item is in flight.
// Items go through one at a time: the block accepts an item, then does the
// read-modify-write of the column store, whose read is registered. A last-row
// item whose column has a nonzero sum then waits on a shared restoring
// divider that retires one quotient bit per cycle over the 22-bit sum.
// Reset: registers return to threshold 128, width and height 2048, position
// at row 0 column 0. The column store is not cleared; row 0 overwrites it.
// Stall: the result sits in an output register; the next pixel is accepted
// and processed meanwhile, and the block holds that one until the register frees.
module laser_line_column_centroid
   import llcc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   llcc_req_if.sink    req_ch,
   llcc_rsp_if.source  rsp_ch,
   llcc_csr_if.sink    csr_ch
);

   // position and compare widths follow the parameters
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WX_W    = $clog2(MAX_WIDTH + 1);
   localparam int HX_W    = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W  = (WX_W > DIM_W) ? WX_W : DIM_W;
   localparam int HCMP_W  = (HX_W > DIM_W) ? HX_W : DIM_W;
   localparam int CX_W    = (COL_W > COLUMN_W) ? COL_W : COLUMN_W;
   localparam int ENTRY_W = SUM_W + CNT_W;
   localparam int DCNT_W  = $clog2(SUM_W);

   localparam logic [WCMP_W-1:0] W_MAX    = WCMP_W'(MAX_WIDTH);
   localparam logic [HCMP_W-1:0] H_MAX    = HCMP_W'(MAX_HEIGHT);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

   // ---------------------------------------------------------------- registers
   logic [PIXEL_W-1:0] threshold_ff;
   logic [DIM_W-1:0]   frame_width_ff;
   logic [DIM_W-1:0]   frame_height_ff;

   state_type state_ff, state_in;

   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;

   // item being worked on
   logic             bright_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             last_row_ff;
   logic             last_frame_ff;
   logic             cen_valid_ff;

   // column store: {sum, count} per column, registered read
   logic [ENTRY_W-1:0] col_mem [MAX_WIDTH];
   logic [ENTRY_W-1:0] mem_rd_ff;

   // divider
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dvs_ff;
   logic [DCNT_W-1:0] div_cnt_ff;

   // output register
   logic                  rsp_valid_ff;
   logic                  out_bin_ff;
   logic [COLUMN_W-1:0]   out_col_ff;
   logic                  out_cen_valid_ff;
   logic [CENTROID_W-1:0] out_cen_row_ff;
   logic                  out_last_ff;

   // ---------------------------------------------------------------- control
   logic accept;
   logic upd_en;
   logic div_step;
   logic load_out;
   logic out_free;

   // ---------------------------------------------------------------- config port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         frame_width_ff  <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_THRESHOLD:    threshold_ff    <= csr_ch.data[PIXEL_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_ch.data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_ch.data[DIM_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- geometry
   // zero acts as one, above the maximum acts as the maximum
   logic [WCMP_W-1:0] w_req, w_eff;
   logic [HCMP_W-1:0] h_req, h_eff;

   always_comb begin
      w_req = WCMP_W'(frame_width_ff);
      h_req = HCMP_W'(frame_height_ff);
      if (w_req == '0)       w_eff = WCMP_W'(1);
      else if (w_req > W_MAX) w_eff = W_MAX;
      else                   w_eff = w_req;
      if (h_req == '0)       h_eff = HCMP_W'(1);
      else if (h_req > H_MAX) h_eff = H_MAX;
      else                   h_eff = h_req;
   end

   // current position (restarts if geometry shrank mid-frame) and next one
   logic [COL_W-1:0]  col_cur;
   logic [ROW_W-1:0]  row_cur;
   logic [WCMP_W-1:0] col_inc;
   logic [HCMP_W-1:0] row_inc;
   logic              cur_last_row;
   logic              cur_last_col;
   logic              cur_bright;

   always_comb begin
      col_cur = (WCMP_W'(col_pos_ff) >= w_eff) ? '0 : col_pos_ff;
      row_cur = (HCMP_W'(row_pos_ff) >= h_eff) ? '0 : row_pos_ff;
      col_inc = WCMP_W'(col_cur) + WCMP_W'(1);
      row_inc = HCMP_W'(row_cur) + HCMP_W'(1);
      cur_last_row = (HCMP_W'(row_cur) == h_eff - HCMP_W'(1));
      cur_last_col = (WCMP_W'(col_cur) == w_eff - WCMP_W'(1));
      cur_bright   = (req_ch.pixel > threshold_ff);
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (accept) begin
         if (col_inc >= w_eff) begin
            col_pos_in = '0;
            row_pos_in = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_pos_in = col_inc[COL_W-1:0];
            row_pos_in = row_cur;
         end
      end
   end

   // ---------------------------------------------------------------- update
   logic [SUM_W-1:0] rd_sum, new_sum;
   logic [CNT_W-1:0] rd_cnt, new_cnt;
   logic             need_div;

   always_comb begin
      rd_sum = mem_rd_ff[ENTRY_W-1:CNT_W];
      rd_cnt = mem_rd_ff[CNT_W-1:0];
      if (row_ff == '0) begin
         // first row overwrites the entry
         new_sum = '0;
         new_cnt = CNT_W'(bright_ff);
      end else if (bright_ff) begin
         new_sum = rd_sum + SUM_W'(row_ff);
         new_cnt = rd_cnt + CNT_W'(1);
      end else begin
         new_sum = rd_sum;
         new_cnt = rd_cnt;
      end
      need_div = last_row_ff && (new_sum != '0) && (new_cnt != '0);
   end

   // ---------------------------------------------------------------- divider step
   logic [CNT_W:0] trial;
   logic [CNT_W:0] diff;
   logic           q_bit;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      q_bit = (trial >= {1'b0, dvs_ff});
   end

   // ---------------------------------------------------------------- FSM
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_ch.valid) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (need_div)      state_in = ST_DIVIDE;
            else if (out_free) state_in = ST_IDLE;
            else               state_in = ST_DELIVER;
         end
         ST_DIVIDE:  if (div_cnt_ff == DIV_LAST) state_in = ST_DELIVER;
         ST_DELIVER: if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      upd_en       = 1'b0;
      div_step     = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_ch.ready = 1'b1;
         ST_UPDATE: begin
            upd_en   = 1'b1;
            load_out = !need_div && out_free;
         end
         ST_DIVIDE:  div_step = 1'b1;
         ST_DELIVER: load_out = out_free;
         default: ;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         if (load_out)          rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- column store
   // one item at a time: the write-back lands before the next item's read
   always_ff @(posedge clock) begin
      if (accept)
         mem_rd_ff <= col_mem[col_cur];
      if (upd_en)
         col_mem[col_ff] <= {new_sum, new_cnt};
   end

   // ---------------------------------------------------------------- datapath
   logic [CX_W-1:0] col_x;

   always_comb begin
      col_x = CX_W'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bright_ff     <= cur_bright;
         col_ff        <= col_cur;
         row_ff        <= row_cur;
         last_row_ff   <= cur_last_row;
         last_frame_ff <= cur_last_row && cur_last_col;
      end
      if (upd_en) begin
         cen_valid_ff <= need_div;
         quo_ff       <= new_sum;
         dvs_ff       <= new_cnt;
         rem_ff       <= '0;
         div_cnt_ff   <= '0;
      end else if (div_step) begin
         quo_ff     <= {quo_ff[SUM_W-2:0], q_bit};
         rem_ff     <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      end
      if (load_out) begin
         out_bin_ff       <= bright_ff;
         out_col_ff       <= col_x[COLUMN_W-1:0];
         out_cen_valid_ff <= cen_valid_ff && (state_ff == ST_DELIVER);
         out_cen_row_ff   <= (cen_valid_ff && (state_ff == ST_DELIVER)) ?
                             quo_ff[CENTROID_W-1:0] : '0;
         out_last_ff      <= last_frame_ff;
      end
   end

   // in ST_UPDATE cen_valid_ff is stale, hence the state qualifier above
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.bin_pixel      = out_bin_ff;
   assign rsp_ch.column         = out_col_ff;
   assign rsp_ch.centroid_valid = out_cen_valid_ff;
   assign rsp_ch.centroid_row   = out_cen_row_ff;
   assign rsp_ch.last_of_frame  = out_last_ff;

endmodule

// ===== dv/tb_laser_line_column_centroid.sv =====
// Self-checking testbench for laser_line_column_centroid: raster frames in,
// one binarized result per pixel out. Depends on llcc_pkg and llcc_channels_if.
`timescale 1ns / 100ps

module tb_laser_line_column_centroid;
   import llcc_pkg::*;

   // Index 3 decodes to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Run limit: about 1k items at their slowest, taken several times over.
   localparam int RUN_LIMIT_NS = 3_000_000;

   // One result item as the block reports it.
   typedef struct packed {
      logic                  bin_pixel;
      logic [COLUMN_W-1:0]   column;
      logic                  centroid_valid;
      logic [CENTROID_W-1:0] centroid_row;
      logic                  last_of_frame;
   } centroid_result_type;

   // ---------------------------------------------------------------------------
   // Column centroid scoreboard: own copy of the registers, the per-column
   // store and the raster position; predicts the result of each accepted pixel
   // and checks results against the oldest prediction.
   // ---------------------------------------------------------------------------
   class centroid_scoreboard;
      logic [PIXEL_W-1:0]  threshold;
      logic [DIM_W-1:0]    frame_width;
      logic [DIM_W-1:0]    frame_height;
      logic [SUM_W-1:0]    row_sum     [DEFAULT_MAX_WIDTH];
      logic [CNT_W-1:0]    bright_count[DEFAULT_MAX_WIDTH];
      bit                  written     [DEFAULT_MAX_WIDTH];
      logic [COLUMN_W-1:0] row_pos;
      logic [COLUMN_W-1:0] col_pos;
      centroid_result_type expected_results[$];
      int                  mismatches;

      function new();
         threshold    = THRESHOLD_RESET;
         frame_width  = DIM_RESET;
         frame_height = DIM_RESET;
         row_pos      = '0;
         col_pos      = '0;
         mismatches   = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      // Zero acts as one, anything above the store size acts as the maximum.
      function logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
         if (v == 0) return DIM_W'(1);
         if (v > maxv) return maxv[DIM_W-1:0];
         return v;
      endfunction

      function int eff_width();
         return clamp_dim(frame_width, DEFAULT_MAX_WIDTH);
      endfunction

      function int eff_height();
         return clamp_dim(frame_height, DEFAULT_MAX_HEIGHT);
      endfunction

      function int frame_pixels();
         return eff_width() * eff_height();
      endfunction

      // Pixels left until the end of the current frame, after any restart
      // that a geometry change forces on the next pixel.
      function int pixels_to_frame_end();
         int w, h, c, r;
         w = eff_width();
         h = eff_height();
         c = (col_pos >= w) ? 0 : col_pos;
         r = (row_pos >= h) ? 0 : row_pos;
         return (h - r) * w - c;
      endfunction

      // A geometry is safe when no later pixel can read a column entry that
      // was never written since reset.
      function bit geometry_safe(logic [DIM_W-1:0] raw_w, logic [DIM_W-1:0] raw_h);
         int w, h, r;
         w = clamp_dim(raw_w, DEFAULT_MAX_WIDTH);
         h = clamp_dim(raw_h, DEFAULT_MAX_HEIGHT);
         r = (row_pos >= h) ? 0 : row_pos;
         if (r == 0) return 1'b1;
         for (int c = 0; c < w; c++)
            if (!written[c]) return 1'b0;
         return 1'b1;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_THRESHOLD:    threshold    = data[PIXEL_W-1:0];
            CSR_FRAME_WIDTH:  frame_width  = data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] px);
         logic [DIM_W-1:0] w, h, next_col, next_row;
         logic [SUM_W-1:0] sum, quotient;
         logic [CNT_W-1:0] cnt;
         logic             bright, last_row;
         centroid_result_type r;
         w = clamp_dim(frame_width, DEFAULT_MAX_WIDTH);
         h = clamp_dim(frame_height, DEFAULT_MAX_HEIGHT);
         // geometry changed mid-frame: out-of-range position restarts
         if (col_pos >= w) col_pos = '0;
         if (row_pos >= h) row_pos = '0;
         bright = (px > threshold);
         if (row_pos == 0) begin
            // first row overwrites the column entry
            sum = '0;
            cnt = bright ? CNT_W'(1) : '0;
         end else begin
            sum = row_sum[col_pos];
            cnt = bright_count[col_pos];
            if (bright) begin
               sum = sum + SUM_W'(row_pos);
               cnt = cnt + CNT_W'(1);
            end
         end
         row_sum[col_pos]      = sum;
         bright_count[col_pos] = cnt;
         written[col_pos]      = 1'b1;

         last_row         = (DIM_W'(row_pos) == h - DIM_W'(1));
         r.bin_pixel      = bright;
         r.column         = col_pos;
         r.centroid_valid = 1'b0;
         r.centroid_row   = '0;
         if (last_row && sum != 0 && cnt != 0) begin
            quotient         = sum / SUM_W'(cnt);
            r.centroid_valid = 1'b1;
            r.centroid_row   = quotient[CENTROID_W-1:0];
         end
         r.last_of_frame = last_row && (DIM_W'(col_pos) == w - DIM_W'(1));
         expected_results.insert(expected_results.size(), r);

         next_col = DIM_W'(col_pos) + DIM_W'(1);
         next_row = DIM_W'(row_pos);
         if (next_col >= w) begin
            next_col = '0;
            next_row = DIM_W'(row_pos) + DIM_W'(1);
            if (next_row >= h) next_row = '0;
         end
         col_pos = next_col[COLUMN_W-1:0];
         row_pos = next_row[COLUMN_W-1:0];
      endfunction

      function void check_result(centroid_result_type got);
         centroid_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: bin %0d col %0d valid %0d row %0d last %0d",
                     $time, got.bin_pixel, got.column, got.centroid_valid,
                     got.centroid_row, got.last_of_frame);
            return;
         end
         want = expected_results[0];
         expected_results.delete(0);
         if (got.bin_pixel !== want.bin_pixel || got.column !== want.column ||
             got.centroid_valid !== want.centroid_valid ||
             got.centroid_row !== want.centroid_row ||
             got.last_of_frame !== want.last_of_frame) begin
            mismatches++;
            // fields: bin / col / valid / row / last
            $display("%0t: mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                     $time, want.bin_pixel, want.column, want.centroid_valid,
                     want.centroid_row, want.last_of_frame, got.bin_pixel, got.column,
                     got.centroid_valid, got.centroid_row, got.last_of_frame);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Clock, channels, block
   // ---------------------------------------------------------------------------
   logic clock;
   logic reset;

   llcc_req_if req_ch ();
   llcc_rsp_if rsp_ch ();
   llcc_csr_if csr_ch ();

   laser_line_column_centroid dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   centroid_scoreboard sb;

   bit steady;       // phase with no idling on either side
   int bright_pct;   // share of pixels drawn above the threshold
   bit result_taken;
   int sink_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side: sample at the rising edge, stall at the falling edge.
   // Each accepted item draws the number of cycles ready stays low next.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result('{bin_pixel: rsp_ch.bin_pixel, column: rsp_ch.column,
                           centroid_valid: rsp_ch.centroid_valid,
                           centroid_row: rsp_ch.centroid_row,
                           last_of_frame: rsp_ch.last_of_frame});
         result_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (result_taken) begin
         result_taken = 1'b0;
         sink_hold    = steady ? 0 : $urandom_range(0, 12);
      end
      if (sink_hold > 0) begin
         rsp_ch.ready = 1'b0;
         sink_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Driving tasks: entered and left right after a falling edge.
   // ---------------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.write_register(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Leaves valid high; the caller lowers it once the burst is over.
   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.pixel = px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_pixel(px);
      @(negedge clock);
   endtask

   // Sends the n lowest bytes of a packed list, leftmost first.
   task automatic send_bytes(input int n, input logic [8*16-1:0] bytes);
      for (int i = n - 1; i >= 0; i--)
         send_pixel(bytes[8*i +: 8]);
      req_ch.valid = 1'b0;
   endtask

   // Mostly pixels on the chosen side of the threshold, some pure noise.
   function automatic logic [PIXEL_W-1:0] draw_pixel();
      int thr;
      thr = sb.threshold;
      if ($urandom_range(0, 3) == 0) return PIXEL_W'($urandom_range(0, 255));
      if ($urandom_range(1, 100) <= bright_pct && thr != 255)
         return PIXEL_W'($urandom_range(thr + 1, 255));
      return PIXEL_W'($urandom_range(0, thr));
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(draw_pixel());
      req_ch.valid = 1'b0;
   endtask

   // Block is idle once every predicted result has come back.
   task automatic wait_idle();
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Height and width 1 force row 0 column 0; finishing that frame lands on
   // a frame start, after which any geometry is safe.
   task automatic align_frame();
      write_csr(CSR_FRAME_HEIGHT, 12'd1);
      write_csr(CSR_FRAME_WIDTH, 12'd1);
      send_random(sb.pixels_to_frame_end());
      wait_idle();
   endtask

   // Mostly small sizes; now and then zero, the maximum, or beyond it.
   function automatic int pick_dim(input int small_max);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(DEFAULT_MAX_WIDTH + 1, 4095);
         2:       return DEFAULT_MAX_WIDTH;
         default: return $urandom_range(1, small_max);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int random_sent, phase, count, rem, frame, new_w, new_h;
      sb           = new();
      steady       = 1'b0;
      bright_pct   = 50;
      result_taken = 1'b0;
      sink_hold    = 0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_THRESHOLD;
      csr_ch.data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // 3x3 frame: column 0 bright on every row (centroid 1), column 1 bright
      // only on row 0 (sum zero, invalid), column 2 never bright; value equal
      // to the threshold is dark.
      write_csr(CSR_THRESHOLD, 12'd100);
      write_csr(CSR_FRAME_WIDTH, 12'd3);
      write_csr(CSR_FRAME_HEIGHT, 12'd3);
      send_bytes(9, 128'({8'd255, 8'd101, 8'd100,
                          8'd200, 8'd0,   8'd100,
                          8'd101, 8'd99,  8'd0}));
      // Stop mid-frame at row 1 column 2, then narrow: column restarts at 0.
      send_bytes(5, 128'({8'd255, 8'd255, 8'd255, 8'd255, 8'd0}));
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, 12'd2);
      send_bytes(2, 128'({8'd255, 8'd0}));
      // Row 0 only: every centroid invalid, each row ends the frame.
      wait_idle();
      write_csr(CSR_FRAME_HEIGHT, 12'd1);
      send_bytes(2, 128'({8'd255, 8'd1}));
      // Threshold 0 and a zero width acting as one column.
      wait_idle();
      write_csr(CSR_THRESHOLD, 12'd0);
      write_csr(CSR_FRAME_WIDTH, 12'd0);
      write_csr(CSR_FRAME_HEIGHT, 12'd2);
      send_bytes(4, 128'({8'd0, 8'd1, 8'd1, 8'd0}));
      // Threshold 255 never bright; oversize width clamps to the maximum.
      wait_idle();
      write_csr(CSR_THRESHOLD, 12'd255);
      write_csr(CSR_FRAME_WIDTH, 12'd4095);
      write_csr(CSR_FRAME_HEIGHT, 12'd1);
      send_bytes(3, 128'({8'd255, 8'd255, 8'd255}));
      wait_idle();
      write_csr(CSR_SPARE, 12'hFFF);
      write_csr(CSR_THRESHOLD, 12'd128);
      write_csr(CSR_FRAME_WIDTH, 12'd2);
      write_csr(CSR_FRAME_HEIGHT, 12'd2);
      send_bytes(4, 128'({8'd128, 8'd129, 8'd255, 8'd0}));

      // --- random phases ---
      random_sent = 0;
      phase       = 0;
      while (random_sent < 600) begin
         wait_idle();
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0:       bright_pct = 0;
            1:       bright_pct = 100;
            default: bright_pct = $urandom_range(5, 95);
         endcase

         if (phase == 3) begin
            // tall frame, one column: large row sums
            align_frame();
            write_csr(CSR_FRAME_WIDTH, 12'd0);
            write_csr(CSR_FRAME_HEIGHT, 12'd150);
            count = sb.frame_pixels();
            send_random(count);
            random_sent += count;
         end else if (phase == 7) begin
            // wide frame, two rows
            align_frame();
            write_csr(CSR_FRAME_WIDTH, 12'd120);
            write_csr(CSR_FRAME_HEIGHT, 12'd2);
            count = sb.frame_pixels();
            send_random(count);
            random_sent += count;
         end else begin
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 5))
                  0:       write_csr(CSR_THRESHOLD, 12'd0);
                  1:       write_csr(CSR_THRESHOLD, 12'd255);
                  default: write_csr(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 255)));
               endcase
            end
            // Geometry may change mid-frame, as long as no never-written
            // column entry can be read afterwards.
            if ($urandom_range(0, 2) != 0) begin
               new_w = pick_dim(8);
               new_h = pick_dim(6);
               if (sb.geometry_safe(DIM_W'(new_w), DIM_W'(new_h))) begin
                  write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(new_w));
                  write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(new_h));
               end else if (sb.geometry_safe(sb.frame_width, DIM_W'(new_h))) begin
                  write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(new_h));
               end
            end
            if ($urandom_range(0, 15) == 0)
               write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 4095)));

            rem   = sb.pixels_to_frame_end();
            frame = sb.frame_pixels();
            if ($urandom_range(0, 3) == 0)
               count = $urandom_range(1, 12);
            else if (rem <= 200)
               count = rem + ((frame <= 60) ? frame * $urandom_range(0, 2) : 0);
            else
               count = $urandom_range(1, 40);
            send_random(count);
            random_sent += count;
         end
         phase++;
      end

      // --- drain ---
      wait_idle();
      repeat (30) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
